>>> hw/rtl/fsar_pkg.sv
// Shared types and constants for the fractional-step audio resampler.
// Used by fractional_step_audio_resampler_top; no dependencies.
`timescale 1ns / 1ps

package fsar_pkg;

    // Default structure sizes
    localparam int STORE_DEPTH_DEF = 1024;
    localparam int FRAC_WIDTH_DEF  = 14;
    localparam int MAX_BURST_DEF   = 64;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 24;
    localparam int STEP_W   = 20;
    localparam int GAIN_W   = 10;
    localparam int CGAIN_W  = 12;   // (input_gain * source_gain) >> 8
    localparam int OUT_W    = 21;
    localparam int OIDX_W   = 16;
    localparam int COUNT_W  = 7;
    localparam int ADDR_W   = 10;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Command codes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_GEN   = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    // Register indexes (word address)
    localparam logic [1:0] REG_STEP  = 2'd0;
    localparam logic [1:0] REG_IGAIN = 2'd1;
    localparam logic [1:0] REG_SGAIN = 2'd2;

    // Register reset values
    localparam logic [STEP_W-1:0] STEP_RESET = 20'd16384;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'h100;

    // Control states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Per-output resampling method
    typedef enum logic [1:0] {
        METH_PASS,
        METH_INTERP,
        METH_AVG
    } t_method;

endpackage

>>> hw/rtl/fractional_step_audio_resampler_top.sv
// Fractional-step audio resampler: sample store, read position, gain and output pipeline.
// Depends on fsar_pkg for types, codes and default sizes.
`timescale 1ns / 1ps

// A write-sample or load-position command leaves busy low. A generate
// command for n outputs (count saturated to MAX_BURST; zero does nothing)
// holds busy while it issues outputs and until they have left the store read
// and interpolate stages: the store is read at two addresses per cycle, so one
// output is issued per cycle, and each output leaves a three-stage pipeline
// (store read, interpolate, gain) as a one-cycle o_valid strobe. Outputs
// cannot be held off, so the receiver must take one on every strobe. The
// store has no reset and needs no clearing pass; an entry must be written
// before a generate command reads it. STORE_DEPTH must be a power of two.
module fractional_step_audio_resampler_top #(
    parameter int STORE_DEPTH = fsar_pkg::STORE_DEPTH_DEF,
    parameter int FRAC_WIDTH  = fsar_pkg::FRAC_WIDTH_DEF,
    parameter int MAX_BURST   = fsar_pkg::MAX_BURST_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_mode,
    input  logic [fsar_pkg::ADDR_W-1:0]           i_address,
    input  logic signed [fsar_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  logic [fsar_pkg::COUNT_W-1:0]          i_count,
    input  logic [fsar_pkg::POS_W-1:0]            i_new_position,
    // result channel
    output logic                                  o_valid,
    output logic signed [fsar_pkg::OUT_W-1:0]     o_sample_out,
    output logic [fsar_pkg::OIDX_W-1:0]           o_out_index,
    output logic                                  o_last,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fsar_pkg::PADDR_W-1:0]          paddr,
    input  logic [fsar_pkg::PDATA_W-1:0]          pwdata,
    output logic [fsar_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);

    localparam int IDX_W   = $clog2(STORE_DEPTH);
    localparam int CNT_W   = $clog2(MAX_BURST + 1);
    localparam int SUM_W   = FRAC_WIDTH + 19;
    localparam logic [fsar_pkg::STEP_W-1:0] STEP_ONE    =
        fsar_pkg::STEP_W'(1 << FRAC_WIDTH);
    localparam logic [fsar_pkg::STEP_W-1:0] STEP_INTLIM =
        fsar_pkg::STEP_W'((1 << (FRAC_WIDTH + 1)) - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [fsar_pkg::STEP_W-1:0]  r_step;
    logic [fsar_pkg::GAIN_W-1:0]  r_igain;
    logic [fsar_pkg::GAIN_W-1:0]  r_sgain;
    logic [fsar_pkg::CGAIN_W-1:0] r_gain;
    logic                         cfg_wr;
    logic [1:0]                   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    // Write registers on the access phase of a write transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= fsar_pkg::STEP_RESET;
            r_igain <= fsar_pkg::GAIN_RESET;
            r_sgain <= fsar_pkg::GAIN_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                fsar_pkg::REG_STEP:  r_step  <= pwdata[fsar_pkg::STEP_W-1:0];
                fsar_pkg::REG_IGAIN: r_igain <= pwdata[fsar_pkg::GAIN_W-1:0];
                fsar_pkg::REG_SGAIN: r_sgain <= pwdata[fsar_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back registers
    always_comb begin
        case (cfg_idx)
            fsar_pkg::REG_STEP:  prdata = fsar_pkg::PDATA_W'(r_step);
            fsar_pkg::REG_IGAIN: prdata = fsar_pkg::PDATA_W'(r_igain);
            fsar_pkg::REG_SGAIN: prdata = fsar_pkg::PDATA_W'(r_sgain);
            default:             prdata = '0;
        endcase
    end

    // Combine the two gains; registers are to change only while idle (not enforced here)
    always_ff @(posedge i_clk) begin
        r_gain <= fsar_pkg::CGAIN_W'((20'(r_igain) * 20'(r_sgain)) >> 8);
    end

    // ------------------------------------------------------------------
    // Command decode and control
    // ------------------------------------------------------------------
    fsar_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]            r_left, n_left;
    logic [fsar_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [fsar_pkg::OIDX_W-1:0] r_widx, n_widx;
    logic                        accept;
    logic                        acc_write;
    logic                        acc_gen;
    logic                        acc_load;
    logic [CNT_W-1:0]            burst_n;
    logic                        issue;
    logic                        r_v1, r_v2, r_v3;

    assign accept    = start && !busy;
    assign acc_write = accept && (i_mode == fsar_pkg::MODE_WRITE);
    assign acc_gen   = accept && (i_mode == fsar_pkg::MODE_GEN);
    assign acc_load  = accept && (i_mode == fsar_pkg::MODE_LOAD);
    assign burst_n   = (i_count > fsar_pkg::COUNT_W'(MAX_BURST)) ?
                       CNT_W'(MAX_BURST) : CNT_W'(i_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fsar_pkg::ST_IDLE: begin
                if (acc_gen && (burst_n != '0)) begin
                    n_state = fsar_pkg::ST_RUN;
                end
            end
            fsar_pkg::ST_RUN: begin
                if (r_left == CNT_W'(1)) begin
                    n_state = fsar_pkg::ST_IDLE;
                end
            end
            default: n_state = fsar_pkg::ST_IDLE;
        endcase
    end

    // State outputs: issue one store read per cycle while running
    always_comb begin
        case (r_state)
            fsar_pkg::ST_RUN: begin
                issue = 1'b1;
                busy  = 1'b1;
            end
            default: begin
                issue = 1'b0;
                busy  = r_v1 || r_v2;
            end
        endcase
    end

    // Advance position, output index and burst counter
    always_comb begin
        n_pos  = r_pos;
        n_widx = r_widx;
        n_left = r_left;
        if (acc_load) begin
            n_pos  = i_new_position;
            n_widx = '0;
        end else if (acc_gen) begin
            n_left = burst_n;
        end else if (issue) begin
            n_pos  = r_pos + fsar_pkg::POS_W'(r_step);
            n_widx = r_widx + fsar_pkg::OIDX_W'(1);
            n_left = r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsar_pkg::ST_IDLE;
            r_left  <= '0;
            r_pos   <= '0;
            r_widx  <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_pos   <= n_pos;
            r_widx  <= n_widx;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: address generation and store access
    // ------------------------------------------------------------------
    logic signed [fsar_pkg::SAMPLE_W-1:0] mem [STORE_DEPTH];
    logic signed [fsar_pkg::SAMPLE_W-1:0] r_rd_a, r_rd_b;
    logic [fsar_pkg::POS_W-1:0]    p_full;
    logic [fsar_pkg::STEP_W-1:0]   hstep;
    logic [15:0]                   addr_ext;
    logic [IDX_W-1:0]              wr_idx, rd_idx_a, rd_idx_b;
    fsar_pkg::t_method             meth;
    fsar_pkg::t_method             r1_meth;
    logic [FRAC_WIDTH-1:0]         r1_frac;
    logic [fsar_pkg::OIDX_W-1:0]   r1_idx;
    logic                          r1_last;

    assign addr_ext = 16'(i_address);
    assign wr_idx   = addr_ext[IDX_W-1:0];
    assign p_full   = r_pos >> FRAC_WIDTH;
    assign hstep    = r_step >> (FRAC_WIDTH + 1);
    assign rd_idx_a = p_full[IDX_W-1:0];

    // Pick the method and the second neighbor from the step
    always_comb begin
        if (r_step == STEP_ONE) begin
            meth     = fsar_pkg::METH_PASS;
            rd_idx_b = rd_idx_a + IDX_W'(1);
        end else if (r_step < STEP_INTLIM) begin
            meth     = fsar_pkg::METH_INTERP;
            rd_idx_b = rd_idx_a + IDX_W'(1);
        end else begin
            meth     = fsar_pkg::METH_AVG;
            rd_idx_b = rd_idx_a + hstep[IDX_W-1:0];
        end
    end

    // Store: one write port, two registered read ports; writes and reads
    // never fall in the same command, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (acc_write) begin
            mem[wr_idx] <= i_sample_value;
        end
        if (issue) begin
            r_rd_a <= mem[rd_idx_a];
            r_rd_b <= mem[rd_idx_b];
        end
    end

    // Carry per-output control alongside the read
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r1_meth <= meth;
            r1_frac <= r_pos[FRAC_WIDTH-1:0];
            r1_idx  <= r_widx;
            r1_last <= (r_left == CNT_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: interpolate or average, pick gain
    // ------------------------------------------------------------------
    logic signed [16:0]              diff;
    logic signed [FRAC_WIDTH+17:0]   prod_b;
    logic signed [SUM_W-1:0]         isum;
    logic signed [SUM_W-1:0]         ishift;
    logic signed [16:0]              s_val;
    logic [fsar_pkg::CGAIN_W-1:0]    g_val;
    logic signed [16:0]              r2_s;
    logic [fsar_pkg::CGAIN_W-1:0]    r2_gm;
    logic [fsar_pkg::OIDX_W-1:0]     r2_idx;
    logic                            r2_last;

    // a*(1-f) + b*f rewritten as a + (b-a)*f
    assign diff   = {r_rd_b[15], r_rd_b} - {r_rd_a[15], r_rd_a};
    assign prod_b = diff * $signed({1'b0, r1_frac});
    assign isum   = ($signed(SUM_W'(r_rd_a)) <<< FRAC_WIDTH) + SUM_W'(prod_b);
    assign ishift = isum >>> FRAC_WIDTH;

    always_comb begin
        case (r1_meth)
            fsar_pkg::METH_PASS: begin
                s_val = {r_rd_a[15], r_rd_a};
                g_val = r_gain;
            end
            fsar_pkg::METH_INTERP: begin
                s_val = ishift[16:0];
                g_val = r_gain;
            end
            default: begin
                s_val = {r_rd_a[15], r_rd_a} + {r_rd_b[15], r_rd_b};
                g_val = r_gain >> 1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r2_s    <= s_val;
            r2_gm   <= g_val;
            r2_idx  <= r1_idx;
            r2_last <= r1_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: apply gain, drive result
    // ------------------------------------------------------------------
    logic signed [29:0]              prod_c;
    logic signed [fsar_pkg::OUT_W-1:0] r_out;
    logic [fsar_pkg::OIDX_W-1:0]     r_oidx;
    logic                            r_olast;

    assign prod_c = r2_s * $signed({1'b0, r2_gm});

    // Floor shift by 8 is an arithmetic slice
    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_out   <= prod_c[28:8];
            r_oidx  <= r2_idx;
            r_olast <= r2_last;
        end
    end

    assign o_valid      = r_v3;
    assign o_sample_out = r_out;
    assign o_out_index  = r_oidx;
    assign o_last       = r_olast;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_gen_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_gen && (burst_n != '0)) |=> busy)
        else $error("generate transaction did not raise busy");

    a_run_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsar_pkg::ST_RUN) |-> (r_left != '0))
        else $error("running with no outputs left");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("output after the final output of a burst");

    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (!r_v1 && !r_v2 && (r_state == fsar_pkg::ST_IDLE)))
        else $error("pipeline not empty at final output");

endmodule
